>>> src/stereo_nonlinear_two_pole_lowpass_unit_macros.svh
// Assertion macros shared by the checker of the stereo lowpass unit.
`ifndef STEREO_NONLINEAR_TWO_POLE_LOWPASS_UNIT_MACROS_SVH
`define STEREO_NONLINEAR_TWO_POLE_LOWPASS_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SNTPL_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SNTPL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/sntpl_pkg.sv
// Package with types and constants of the stereo nonlinear two-pole lowpass unit.
package sntpl_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int TANH_TABLE_ENTRIES = 256;
	localparam int FRAC_BITS = SAMPLE_BITS - 1;
	localparam int UP_SHIFT = (FRAC_BITS < 28) ? (28 - FRAC_BITS) : 0;
	localparam int DN_SHIFT = (FRAC_BITS > 28) ? (FRAC_BITS - 28) : 0;
	localparam logic [23:0] OMEGA_RESET = 24'd562210;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left_in;
		logic signed [SAMPLE_BITS-1:0] right_in;
		logic [15:0] cutoff_hz;
		logic [15:0] resonance;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left_out;
		logic signed [SAMPLE_BITS-1:0] right_out;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WCT,
		ST_ALPHA,
		ST_ARG,
		ST_IDX,
		ST_LERP,
		ST_FRAC,
		ST_ONE,
		ST_TWO,
		ST_WRAP
	} state_t;

	typedef struct packed {
		logic load;
		logic mul_step;
		logic div_step;
	} ctl_t;

endpackage

>>> src/stereo_nonlinear_two_pole_lowpass_unit.sv
// Each accepted item passes through a sequencer that filters the left and then the right
// channel with the bit-serial shift-add multiplier and the restoring divider that it shares
// over all products and quotients; sample_stall holds off new items until ST_IDLE.
// A new item is taken while the previous result still waits at the output register.
// Reset is asynchronous: filter stages clear to zero and omega_q returns to 562210.
module stereo_nonlinear_two_pole_lowpass_unit
	import sntpl_pkg::*;
#(
	parameter int TANH_ENTRIES = TANH_TABLE_ENTRIES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [23:0] cfg_data,
	input  logic        sample_valid,
	output logic        sample_stall,
	input  in_item_t    sample,
	output logic        result_valid,
	input  logic        result_stall,
	output out_item_t   result
);

	localparam int IW = $clog2(TANH_ENTRIES + 1);
	localparam int PSW = 30 + IW;
	localparam int OW = 33 + DN_SHIFT;
	localparam logic [46:0] SPAN = 47'd3 << 28;

	state_t state_q, state_d;
	ctl_t ctl;
	logic [4:0] cnt_q, last_c;
	logic done, go;

	logic [23:0] omega_q;
	in_item_t in_q;
	logic chan_q;
	logic [23:0] alpha_q;
	logic signed [31:0] one_q [2];
	logic signed [31:0] two_q [2];
	logic out_valid_q;
	out_item_t out_q;

	logic signed [59:0] m_q, acc_q;
	logic [24:0] b_q;
	logic [41:0] r_q;
	logic [40:0] d_q;
	logic [25:0] s_q, q_q;

	logic neg_q, sat_q;
	logic [27:0] rem_lo_q;
	logic [24:0] v0_q;

	logic [24:0] knot_tab [0:TANH_ENTRIES];

	for (genvar k = 0; k <= TANH_ENTRIES; k++) begin : g_knot
		localparam longint KK = longint'(k);
		localparam longint NN = longint'(TANH_ENTRIES);
		localparam longint KNUM = KK * (3 * NN * NN + KK * KK);
		localparam longint KDEN = NN * (NN * NN + 3 * KK * KK);
		localparam longint KVAL = (KNUM <<< 24) / KDEN;
		assign knot_tab[k] = 25'(KVAL);
	end

	function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
		logic signed [36:0] lo;
		logic signed [36:0] hi;
		lo = -(37'sd1 <<< 31);
		hi = (37'sd1 <<< 31) - 37'sd1;
		if (v < lo) begin
			return 32'h8000_0000;
		end else if (v > hi) begin
			return 32'h7fff_ffff;
		end
		return v[31:0];
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] sample_out(input logic signed [31:0] y);
		logic signed [OW-1:0] v;
		logic signed [OW-1:0] lim;
		v = (OW'(y) >>> UP_SHIFT) <<< DN_SHIFT;
		lim = OW'(1) <<< FRAC_BITS;
		if (v < -lim) begin
			v = -lim;
		end else if (v > lim - OW'(1)) begin
			v = lim - OW'(1);
		end
		return v[SAMPLE_BITS-1:0];
	endfunction

	logic signed [SAMPLE_BITS-1:0] xs_c;
	logic signed [33:0] x_c, d_c, diff1_c, fb_c;
	logic signed [31:0] one_c, two_c, new_one_c, new_two_c;
	logic [17:0] reso3_c;
	logic signed [46:0] arg_c;
	logic [46:0] mag_c;
	logic [PSW-1:0] pos_c;
	logic [IW-1:0] idx_c, idx1_c;
	logic [24:0] tanh_c;
	logic [41:0] rr_c;
	logic ge_c;

	always_comb begin
		xs_c = chan_q ? in_q.right_in : in_q.left_in;
		x_c = (34'(xs_c) <<< UP_SHIFT) >>> DN_SHIFT;
		one_c = one_q[chan_q];
		two_c = two_q[chan_q];
		d_c = 34'(two_c) - x_c;
		reso3_c = {1'b0, in_q.resonance, 1'b0} + 18'(in_q.resonance);
		arg_c = acc_q[59:13];
		mag_c = arg_c[46] ? 47'(-arg_c) : 47'(arg_c);
		pos_c = PSW'(mag_c[29:0]) * PSW'(TANH_ENTRIES);
		idx_c = q_q[IW-1:0];
		idx1_c = idx_c + IW'(1);
		tanh_c = sat_q ? (25'd1 << 24) : v0_q + q_q[24:0];
		fb_c = neg_q ? -(34'(tanh_c) <<< 4) : (34'(tanh_c) <<< 4);
		diff1_c = x_c - fb_c - 34'(one_c);
		new_one_c = sat32(37'(one_c) + 37'(acc_q >>> 24));
		new_two_c = sat32(37'(two_c) + 37'(acc_q >>> 24));
		rr_c = {r_q[40:0], s_q[25]};
		ge_c = rr_c >= {1'b0, d_q};
	end

	assign go = !(chan_q && out_valid_q && result_stall);
	assign done = cnt_q == last_c;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (sample_valid) state_d = ST_WCT;
			end
			ST_WCT: begin
				if (done) state_d = ST_ALPHA;
			end
			ST_ALPHA: begin
				if (done) state_d = ST_ARG;
			end
			ST_ARG: begin
				if (done) state_d = ST_IDX;
			end
			ST_IDX: begin
				if (done) state_d = ST_LERP;
			end
			ST_LERP: begin
				if (done) state_d = ST_FRAC;
			end
			ST_FRAC: begin
				if (done) state_d = ST_ONE;
			end
			ST_ONE: begin
				if (done) state_d = ST_TWO;
			end
			ST_TWO: begin
				if (done) state_d = ST_WRAP;
			end
			ST_WRAP: begin
				if (go) state_d = chan_q ? ST_IDLE : ST_ARG;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl = '0;
		last_c = 5'd0;
		case (state_q)
			ST_WCT: begin
				last_c = 5'd16;
				ctl.mul_step = cnt_q != 5'd0;
			end
			ST_ALPHA: begin
				last_c = 5'd24;
				ctl.div_step = cnt_q != 5'd0;
			end
			ST_ARG: begin
				last_c = 5'd18;
				ctl.mul_step = cnt_q != 5'd0;
			end
			ST_IDX: begin
				last_c = 5'd26;
				ctl.div_step = cnt_q != 5'd0;
			end
			ST_LERP: begin
				last_c = 5'd25;
				ctl.mul_step = cnt_q != 5'd0;
			end
			ST_FRAC: begin
				last_c = 5'd26;
				ctl.div_step = cnt_q != 5'd0;
			end
			ST_ONE, ST_TWO: begin
				last_c = 5'd24;
				ctl.mul_step = cnt_q != 5'd0;
			end
			default: begin
				last_c = 5'd0;
			end
		endcase
		ctl.load = (state_q != ST_IDLE) && (state_q != ST_WRAP) && (cnt_q == 5'd0);
	end

	assign sample_stall = state_q != ST_IDLE;
	assign cfg_ready = 1'b1;
	assign result_valid = out_valid_q;
	assign result = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= 5'd0;
			chan_q <= 1'b0;
			omega_q <= OMEGA_RESET;
			one_q[0] <= '0;
			one_q[1] <= '0;
			two_q[0] <= '0;
			two_q[1] <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE || state_q == ST_WRAP || done) begin
				cnt_q <= 5'd0;
			end else begin
				cnt_q <= cnt_q + 5'd1;
			end
			if (cfg_valid && cfg_ready) omega_q <= cfg_data;
			if (state_q == ST_IDLE) chan_q <= 1'b0;
			if (state_q == ST_TWO && ctl.load) one_q[chan_q] <= new_one_c;
			if (state_q == ST_WRAP && go) begin
				two_q[chan_q] <= new_two_c;
				chan_q <= !chan_q;
			end
			if (state_q == ST_WRAP && go && chan_q) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && !sample_stall) in_q <= sample;
		if (state_q == ST_WRAP && go && chan_q) begin
			out_q.left_out <= sample_out(two_q[0]);
			out_q.right_out <= sample_out(new_two_c);
		end
		if (ctl.mul_step) begin
			if (b_q[0]) acc_q <= acc_q + m_q;
			m_q <= m_q <<< 1;
			b_q <= b_q >> 1;
		end
		if (ctl.div_step) begin
			r_q <= ge_c ? rr_c - {1'b0, d_q} : rr_c;
			q_q <= {q_q[24:0], ge_c};
			s_q <= s_q << 1;
		end
		if (ctl.load) begin
			case (state_q)
				ST_WCT: begin
					m_q <= 60'(omega_q);
					b_q <= 25'(in_q.cutoff_hz);
					acc_q <= '0;
				end
				ST_ALPHA: begin
					r_q <= 42'(acc_q[39:0]);
					d_q <= (41'd1 << 32) + 41'(acc_q[39:0]);
					s_q <= '0;
					q_q <= '0;
				end
				ST_ARG: begin
					if (!chan_q) alpha_q <= q_q[23:0];
					m_q <= 60'(d_c);
					b_q <= 25'(reso3_c);
					acc_q <= '0;
				end
				ST_IDX: begin
					neg_q <= arg_c[46];
					sat_q <= mag_c >= SPAN;
					rem_lo_q <= pos_c[27:0];
					r_q <= '0;
					d_q <= 41'd3;
					s_q <= 26'(pos_c[PSW-1:28]);
					q_q <= '0;
				end
				ST_LERP: begin
					v0_q <= knot_tab[idx_c];
					b_q <= knot_tab[idx1_c] - knot_tab[idx_c];
					m_q <= 60'({r_q[1:0], rem_lo_q});
					acc_q <= '0;
				end
				ST_FRAC: begin
					r_q <= '0;
					d_q <= 41'd3;
					s_q <= acc_q[53:28];
					q_q <= '0;
				end
				ST_ONE: begin
					m_q <= 60'(diff1_c);
					b_q <= 25'(alpha_q);
					acc_q <= '0;
				end
				ST_TWO: begin
					m_q <= 60'(34'(new_one_c) - 34'(two_c));
					b_q <= 25'(alpha_q);
					acc_q <= '0;
				end
				default: begin
					acc_q <= acc_q;
				end
			endcase
		end
	end

endmodule

>>> src/sntpl_checker.sv
// Port checker of the stereo lowpass unit and its bind to the top level.
`include "stereo_nonlinear_two_pole_lowpass_unit_macros.svh"

module sntpl_checker
	import sntpl_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      sample_valid,
	input logic      sample_stall,
	input logic      result_valid,
	input logic      result_stall,
	input out_item_t result
);

	`SNTPL_ASSERT_NEXT(a_result_holds, clk, arst_n, result_valid && result_stall, result_valid && $stable(result), "A stalled result item changed.")
	`SNTPL_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, sample_valid && !sample_stall, sample_stall, "The unit did not turn busy after taking an item.")
	`SNTPL_ASSERT_SAME(a_idle_on_result, clk, arst_n, $rose(result_valid), !sample_stall, "A result item appeared while the unit was still busy.")

endmodule

bind stereo_nonlinear_two_pole_lowpass_unit sntpl_checker u_sntpl_checker (
	.clk(clk),
	.arst_n(arst_n),
	.sample_valid(sample_valid),
	.sample_stall(sample_stall),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.result(result)
);

>>> verif/testbench.sv
// Self-checking testbench for the stereo nonlinear two-pole lowpass unit.
module testbench;
	import sntpl_pkg::*;

	localparam int TANH_N = TANH_TABLE_ENTRIES;
	localparam longint TANH_SPAN = longint'(3) << 28;
	localparam longint ONE_Q24 = longint'(1) << 24;
	localparam int LATENCY = 400;
	localparam int CYCLE_LIMIT = 3000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [23:0] cfg_data = '0;
	logic sample_valid = 1'b0;
	logic sample_stall;
	in_item_t sample = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	out_item_t result;

	in_item_t pending_samples[$];
	out_item_t expected_pairs[$];
	logic [23:0] omega;
	logic signed [31:0] l_one, l_two, r_one, r_two;
	int error_count = 0;
	int cycle_count = 0;
	bit idle_enable = 1'b1;
	bit hold_output = 1'b0;
	bit in_taken = 1'b0;
	int send_gap = 0;
	int recv_gap = 0;

	stereo_nonlinear_two_pole_lowpass_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
		.result_valid(result_valid), .result_stall(result_stall), .result(result)
	);

	always #4 clk = ~clk;

	function automatic longint floor_shift(longint v, int n);
		if (v >= 0) return v >>> n;
		return -1 - ((-1 - v) >>> n);
	endfunction

	function automatic longint clamp(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint tanh_knot(longint k);
		longint n;
		n = TANH_N;
		return ((k * (3 * n * n + k * k)) <<< 24) / (n * (n * n + 3 * k * k));
	endfunction

	function automatic longint soft_tanh(longint x);
		longint a, p, idx, rem, v0, v1, r;
		a = x < 0 ? -x : x;
		if (a >= TANH_SPAN) begin
			r = ONE_Q24;
		end else begin
			p = a * TANH_N;
			idx = p / TANH_SPAN;
			rem = p % TANH_SPAN;
			v0 = tanh_knot(idx);
			v1 = tanh_knot(idx + 1);
			r = v0 + ((v1 - v0) * rem) / TANH_SPAN;
		end
		return x < 0 ? -r : r;
	endfunction

	function automatic logic signed [31:0] integrate(logic signed [31:0] s, longint drive,
			longint alpha);
		return 32'(clamp(longint'(s) + floor_shift(alpha * (drive - longint'(s)), 24),
			-(longint'(1) << 31), (longint'(1) << 31) - 1));
	endfunction

	function automatic logic signed [23:0] filter_channel(logic signed [23:0] s,
			ref logic signed [31:0] one, ref logic signed [31:0] two,
			input longint alpha, input longint reso);
		longint x, fb, y;
		x = longint'(s) <<< UP_SHIFT;
		fb = soft_tanh(floor_shift((longint'(two) - x) * reso * 3, 13)) * 16;
		one = integrate(one, x - fb, alpha);
		two = integrate(two, longint'(one), alpha);
		y = floor_shift(longint'(two), UP_SHIFT);
		return 24'(clamp(y, -(longint'(1) << FRAC_BITS), (longint'(1) << FRAC_BITS) - 1));
	endfunction

	function automatic out_item_t filter_pair(in_item_t it);
		out_item_t o;
		longint unsigned wct;
		longint alpha;
		wct = longint'(it.cutoff_hz) * longint'(omega);
		alpha = longint'((wct << 24) / ((64'd1 << 32) + wct));
		o.left_out = filter_channel(it.left_in, l_one, l_two, alpha, longint'(it.resonance));
		o.right_out = filter_channel(it.right_in, r_one, r_two, alpha, longint'(it.resonance));
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [23:0] got, logic [23:0] want);
		$display("Mismatch on %s: got %0d expected %0d", what, $signed(got), $signed(want));
		error_count++;
	endtask

	// Driver.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!sample_valid || in_taken) begin
				if (send_gap > 0) begin
					send_gap--;
					sample_valid <= 1'b0;
				end else if (pending_samples.size() > 0 &&
						!(idle_enable && $urandom_range(0, 9) == 0)) begin
					sample <= pending_samples.pop_front();
					sample_valid <= 1'b1;
				end else begin
					if (idle_enable) send_gap = $urandom_range(0, 6);
					sample_valid <= 1'b0;
				end
			end
			if (hold_output) begin
				result_stall <= 1'b1;
			end else if (recv_gap > 0) begin
				recv_gap--;
				result_stall <= 1'b1;
			end else if (idle_enable && $urandom_range(0, 9) == 0) begin
				recv_gap = $urandom_range(0, 6);
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// Monitor: the prediction is made when an item is accepted.
	always @(posedge clk) begin
		out_item_t want;
		cycle_count++;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_pairs.size() == 0) begin
				$display("Unexpected result item");
				error_count++;
			end else begin
				want = expected_pairs.pop_front();
				if (result.left_out !== want.left_out)
					report_mismatch("left_out", result.left_out, want.left_out);
				if (result.right_out !== want.right_out)
					report_mismatch("right_out", result.right_out, want.right_out);
			end
		end
		in_taken = arst_n && sample_valid && !sample_stall;
		if (in_taken) expected_pairs.push_back(filter_pair(sample));
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic in_item_t random_sample(bit heavy);
		in_item_t it;
		it.left_in = 24'($urandom);
		it.right_in = $urandom_range(0, 3) == 0 ? 24'($urandom) : it.left_in;
		case ($urandom_range(0, 3))
			0: it.cutoff_hz = 16'($urandom);
			1: it.cutoff_hz = 16'($urandom_range(0, 255));
			default: it.cutoff_hz = 16'($urandom_range(0, 20000));
		endcase
		it.resonance = heavy ? 16'($urandom) : 16'($urandom_range(0, 20000));
		return it;
	endfunction

	task automatic drain();
		while (pending_samples.size() > 0 || sample_valid || expected_pairs.size() > 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic write_omega(logic [23:0] v);
		@(negedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		omega = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic in_item_t make_sample(int l, int r, int c, int q);
		in_item_t it;
		it.left_in = 24'(l);
		it.right_in = 24'(r);
		it.cutoff_hz = 16'(c);
		it.resonance = 16'(q);
		return it;
	endfunction

	initial begin
		logic [23:0] omegas[5];
		omega = OMEGA_RESET;
		l_one = 0; l_two = 0; r_one = 0; r_two = 0;
		omegas = '{24'd1, 24'hFFFFFF, 24'd562210, 24'd0, 24'($urandom_range(1, 24'hFFFFFF))};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed items with the reset value of the register.
		pending_samples.push_back(make_sample(8388607, -8388608, 1000, 0));
		pending_samples.push_back(make_sample(8388607, -8388608, 65535, 65535));
		pending_samples.push_back(make_sample(-8388608, 8388607, 65535, 65535));
		pending_samples.push_back(make_sample(0, 0, 0, 65535));
		pending_samples.push_back(make_sample(-1, 1, 0, 0));
		pending_samples.push_back(make_sample(4194304, -4194304, 20000, 4096));
		pending_samples.push_back(make_sample(-8388608, -8388608, 65535, 30000));
		pending_samples.push_back(make_sample(8388607, 8388607, 1, 65535));
		pending_samples.push_back(make_sample(0, 0, 65535, 0));
		pending_samples.push_back(make_sample(-5592405, 5592405, 30000, 12288));
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			write_omega(omegas[ph]);
			if (ph == 1) begin
				// Long hold on the output so that the unit fills and stalls its input.
				for (int i = 0; i < 6; i++) pending_samples.push_back(random_sample(1'b1));
				hold_output = 1'b1;
				repeat (1500) @(posedge clk);
				hold_output = 1'b0;
				drain();
			end
			if (ph == 4) idle_enable = 1'b0;
			for (int i = 0; i < 145; i++) pending_samples.push_back(random_sample(i % 3 == 0));
			drain();
		end

		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
